// ----- rtl/ttrc_pkg.sv -----
// Constants and the mod-65535 fold for the three-term recurrence checksum.
// Self-contained; imported by the three_term_recurrence_checksum top level.
package ttrc_pkg;

  localparam int unsigned TERM_W = 16;
  localparam int unsigned BYTE_W = 8;
  // Width of the biased difference, before folding.
  localparam int unsigned SUM_W  = 26;

  localparam logic [TERM_W-1:0] TERM_MOD     = 16'd65535;
  localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
  localparam logic [BYTE_W-1:0] ALPHA_STEP   = 8'd17;
  localparam logic [BYTE_W-1:0] BETA_STEP    = 8'd31;
  // 256 * 65535: lifts the most negative difference above zero and leaves
  // the residue mod 65535 unchanged.
  localparam logic [SUM_W-1:0]  FOLD_BIAS    = 26'd16776960;

  typedef logic [TERM_W-1:0] term_t;

  // Reduce a value mod 65535, using 2^16 == 1 (mod 65535).
  function automatic term_t mod_fold(input logic [SUM_W-1:0] val);
    logic [TERM_W:0]   f1;
    logic [TERM_W-1:0] f2;
    f1 = {1'b0, val[TERM_W-1:0]} + {7'd0, val[SUM_W-1:TERM_W]};
    f2 = f1[TERM_W-1:0] + {{(TERM_W-1){1'b0}}, f1[TERM_W]};
    return (f2 == TERM_MOD) ? '0 : f2;
  endfunction

endpackage

// ----- rtl/three_term_recurrence_checksum.sv -----
// Three-term recurrence checksum over a byte stream, one byte per cycle while in_stall is low.
// Depends on ttrc_pkg for constants and the mod-65535 fold.
//
// Usage:
//   Input channel (in_valid / in_stall): one message byte per beat, with
//   in_last_byte high on the final byte. Every message has at least one byte.
//   Result channel (out_valid / out_stall): one beat per message, carrying
//   out_checksum, the newest recurrence term after the final byte (0..65534).
//   A beat moves on a rising edge with valid high and stall low.
//
// Timing:
//   An accepted byte lands in the input register, and the edge that moves it
//   on folds it into the running terms; that same edge loads a final byte's
//   checksum into the output register, so out_valid rises as the final byte
//   leaves the input register. Throughput is one byte per cycle while in_stall
//   is low; the limit is the combinational update of the two recurrence terms
//   (two small products, a subtract and a fold).
//
// Stall: while the output register holds an untaken checksum, non-final bytes
//   keep flowing; only a final byte waits in the input register, and then
//   in_stall goes high until the output beat is taken.
// Reset (rst_n low, synchronous): both registers empty, the next byte opens
//   a new message.
module three_term_recurrence_checksum
  import ttrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TERM_W-1:0] out_checksum
);

  // Input register
  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;

  // Recurrence state
  logic [BYTE_W-1:0] pos_r,   pos_nxt;
  term_t             older_r, older_nxt;
  term_t             newer_r, newer_nxt;
  logic              start_r, start_nxt;

  // Result register
  logic              out_v_r;
  term_t             out_checksum_r;

  logic              hold;
  logic              step;
  logic [BYTE_W-1:0] alpha;
  logic [BYTE_W-1:0] beta;
  logic [BYTE_W:0]   coef;
  logic [24:0]       prod_new;
  logic [23:0]       prod_old;
  logic              negative;
  logic [SUM_W-1:0]  biased;
  term_t             term_next;

  // Hold a final byte while the previous checksum is still untaken.
  assign hold     = in_v_r && in_last_r && out_v_r && out_stall;
  assign in_stall = hold;
  assign step     = in_v_r && !hold;

  // Position coefficients, kept mod 256 by the 8-bit width.
  assign alpha = 8'(pos_r * ALPHA_STEP);
  assign beta  = 8'(pos_r * BETA_STEP);
  assign coef  = {1'b0, in_byte_r} + {1'b0, alpha};

  assign prod_new = coef * newer_r;
  assign prod_old = beta * older_r;

  // A negative difference wraps mod 2^64, and 2^64 == 1 (mod 65535): add one.
  assign negative = ({1'b0, prod_new} < {2'b00, prod_old});
  assign biased   = {1'b0, prod_new} + FOLD_BIAS - {2'b00, prod_old}
                    + {{(SUM_W-1){1'b0}}, negative};
  assign term_next = mod_fold(biased);

  always_comb begin
    pos_nxt   = pos_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    start_nxt = start_r;
    if (step) begin
      if (start_r) begin
        // Open a message: load the first term.
        newer_nxt = {{(TERM_W-BYTE_W){1'b0}}, in_byte_r} + FIRST_OFFSET;
        older_nxt = term_t'(1);
        pos_nxt   = 8'd1;
        start_nxt = 1'b0;
      end else begin
        // Advance the recurrence and shift the terms.
        older_nxt = newer_r;
        newer_nxt = term_next;
        pos_nxt   = pos_r + 8'd1;
      end
      if (in_last_r) begin
        // Rearm for the next message.
        pos_nxt   = '0;
        older_nxt = term_t'(1);
        newer_nxt = term_t'(1);
        start_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pos_r   <= '0;
      older_r <= term_t'(1);
      newer_r <= term_t'(1);
      start_r <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      start_r <= start_nxt;

      // Input register drains every cycle unless a final byte is held.
      if (!hold) begin
        in_v_r <= in_valid;
      end

      // Result register: load on a final byte, drop when taken.
      if (step && in_last_r) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end

    if (!hold) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (step && in_last_r) begin
      out_checksum_r <= start_r
                        ? ({{(TERM_W-BYTE_W){1'b0}}, in_byte_r} + FIRST_OFFSET)
                        : term_next;
    end
  end

  assign out_valid    = out_v_r;
  assign out_checksum = out_checksum_r;

endmodule
